FILE: hw/rtl/tdv_pkg.sv
`timescale 1ns / 1ps

package tdv_pkg;

	localparam int DistW = 15;
	localparam int SampleW = 16;
	localparam int CapW = 20;
	localparam int DenW = 16;
	localparam int NumW = DenW + CapW;
	localparam int StatW = 2;
	localparam int IdxW = 2;

	// Status codes
	localparam logic [StatW-1:0] ST_VALID = 2'd0;
	localparam logic [StatW-1:0] ST_SENSOR = 2'd1;
	localparam logic [StatW-1:0] ST_UNCAL = 2'd2;

	// Register indexes
	localparam logic [IdxW-1:0] REG_EMPTY = 2'd0;
	localparam logic [IdxW-1:0] REG_HALF = 2'd1;
	localparam logic [IdxW-1:0] REG_FULL = 2'd2;
	localparam logic [IdxW-1:0] REG_CAP = 2'd3;

	// Calibration set held at the top level
	typedef struct packed {
		logic [DistW-1:0] empty_lvl;
		logic [DistW-1:0] half_lvl;
		logic [DistW-1:0] full_lvl;
		logic [CapW-1:0]  capacity;
	} cal_t;

	// Multiplier operands and divisor for one request
	typedef struct packed {
		logic [DenW-1:0]  opa;
		logic [CapW-1:0]  opb;
		logic [DenW-1:0]  den;
		logic [StatW-1:0] status;
	} oper_t;

	// Division word handed from cell to cell: partial remainder, then the
	// dividend bits still to consume, which fill up with quotient bits
	typedef struct packed {
		logic [DenW-1:0]  rem;
		logic [CapW-1:0]  nq;
		logic [DenW-1:0]  den;
		logic [StatW-1:0] status;
	} div_t;

endpackage

FILE: hw/rtl/tdv_front.sv
`timescale 1ns / 1ps

module tdv_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tdv_pkg::cal_t                        cal,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic signed [tdv_pkg::SampleW-1:0]   sample,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output tdv_pkg::div_t                        dn_data
);

	logic [tdv_pkg::DistW-1:0] d;
	logic                      d_gt_h;
	tdv_pkg::oper_t            op;
	tdv_pkg::oper_t            op_s1;
	logic                      v_s1;
	logic                      v_s2;
	logic                      rdy_s1;
	logic                      rdy_s2;
	logic [tdv_pkg::NumW-1:0]  num;
	tdv_pkg::div_t             div_s2;

	assign d = sample[tdv_pkg::DistW-1:0];
	assign d_gt_h = d > cal.half_lvl;

	// Pick the segment and form multiplier operands and divisor; fixed
	// results go through as value times one over one
	always_comb begin
		op.opa = '0;
		op.opb = '0;
		op.den = tdv_pkg::DenW'(1);
		op.status = tdv_pkg::ST_VALID;
		if (sample[tdv_pkg::SampleW-1]) begin
			op.status = tdv_pkg::ST_SENSOR;
		end else if (cal.capacity == '0 || cal.empty_lvl == '0) begin
			op.status = tdv_pkg::ST_UNCAL;
		end else if (d >= cal.empty_lvl) begin
			op.opa = '0;
		end else if (d <= cal.full_lvl) begin
			op.opa = tdv_pkg::DenW'(1);
			op.opb = cal.capacity;
		end else if (d_gt_h) begin
			op.opa = tdv_pkg::DenW'(cal.empty_lvl - d);
			op.opb = cal.capacity;
			op.den = {cal.empty_lvl - cal.half_lvl, 1'b0};
		end else begin
			op.opa = tdv_pkg::DenW'({1'b0, cal.half_lvl - cal.full_lvl})
				+ tdv_pkg::DenW'({1'b0, cal.half_lvl - d});
			op.opb = cal.capacity;
			op.den = {cal.half_lvl - cal.full_lvl, 1'b0};
		end
	end

	assign rdy_s2 = !v_s2 || dn_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// Hold or advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// Operand stage
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) op_s1 <= op;
	end

	assign num = op_s1.opa * op_s1.opb;

	// Product stage: top bits seed the remainder, always below the divisor
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			div_s2.rem <= num[tdv_pkg::NumW-1:tdv_pkg::CapW];
			div_s2.nq <= num[tdv_pkg::CapW-1:0];
			div_s2.den <= op_s1.den;
			div_s2.status <= op_s1.status;
		end
	end

	assign dn_valid = v_s2;
	assign dn_data = div_s2;

endmodule

FILE: hw/rtl/tdv_div_cell.sv
`timescale 1ns / 1ps

module tdv_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  tdv_pkg::div_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output tdv_pkg::div_t dn_data
);

	logic [tdv_pkg::DenW:0]   trial;
	logic [tdv_pkg::DenW:0]   diff;
	logic                     ge;
	logic                     v_q;
	tdv_pkg::div_t            d_q;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {up_data.rem, up_data.nq[tdv_pkg::CapW-1]};
	assign ge = trial >= {1'b0, up_data.den};
	assign diff = trial - {1'b0, up_data.den};

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_q.rem <= ge ? diff[tdv_pkg::DenW-1:0] : trial[tdv_pkg::DenW-1:0];
			d_q.nq <= {up_data.nq[tdv_pkg::CapW-2:0], ge};
			d_q.den <= up_data.den;
			d_q.status <= up_data.status;
		end
	end

	assign dn_valid = v_q;
	assign dn_data = d_q;

endmodule

FILE: hw/rtl/tank_distance_to_volume.sv
`timescale 1ns / 1ps

// An accepted request passes operand select and multiply in the front, then
// 20 division cells, one quotient bit each, before its result reaches the outputs.
// Throughput: one request per cycle while out_stall does not back up the row;
// each cell stalls only when it is full and its neighbour downstream is stalled.
// Reset clears all valid flags and the calibration registers to zero.
module tank_distance_to_volume (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tdv_pkg::IdxW-1:0]            cfg_index,
	input  logic [tdv_pkg::CapW-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tdv_pkg::SampleW-1:0]  distance_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tdv_pkg::CapW-1:0]            volume_out,
	output logic [tdv_pkg::StatW-1:0]           status_code
);

	localparam int Cells = tdv_pkg::CapW;

	tdv_pkg::cal_t cal_q;
	logic          front_ready;
	logic          cv [Cells+1];
	logic          cr [Cells+1];
	tdv_pkg::div_t cd [Cells+1];

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tdv_pkg::REG_EMPTY: cal_q.empty_lvl <= cfg_data[tdv_pkg::DistW-1:0];
				tdv_pkg::REG_HALF:  cal_q.half_lvl <= cfg_data[tdv_pkg::DistW-1:0];
				tdv_pkg::REG_FULL:  cal_q.full_lvl <= cfg_data[tdv_pkg::DistW-1:0];
				tdv_pkg::REG_CAP:   cal_q.capacity <= cfg_data;
				default: ;
			endcase
		end
	end

	tdv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal_q),
		.up_valid (in_valid),
		.up_ready (front_ready),
		.sample   (distance_sample),
		.dn_valid (cv[0]),
		.dn_ready (cr[0]),
		.dn_data  (cd[0])
	);

	assign in_stall = !front_ready;

	// Row of division cells, one quotient bit each
	for (genvar k = 0; k < Cells; k++) begin : g_cell
		tdv_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[k]),
			.up_ready (cr[k]),
			.up_data  (cd[k]),
			.dn_valid (cv[k+1]),
			.dn_ready (cr[k+1]),
			.dn_data  (cd[k+1])
		);
	end

	assign cr[Cells] = !out_stall;
	assign out_valid = cv[Cells];
	assign volume_out = cd[Cells].nq;
	assign status_code = cd[Cells].status;

endmodule
